>>> hdl/ilid_pkg.sv
// Shared types, sizes and codes for the indexed list block.
// No dependencies; used by every module under hdl.
`timescale 1ns / 1ps

package ilid_pkg;

    // List size and derived widths
    localparam int CAPACITY  = 64;
    localparam int POS_W     = 8;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 7;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GROUP     = 8;
    localparam int NGROUPS   = (CAPACITY + GROUP - 1) / GROUP;

    // Operation codes
    localparam logic [2:0] OP_READ      = 3'd0;
    localparam logic [2:0] OP_INS_HEAD  = 3'd1;
    localparam logic [2:0] OP_INS_TAIL  = 3'd2;
    localparam logic [2:0] OP_INS_AT    = 3'd3;
    localparam logic [2:0] OP_DELETE    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [CNT_W-1:0]         t_cnt;

    // Input item
    typedef struct packed {
        logic [2:0]  op;
        t_pos        position;
        t_data       value;
    } t_item;

    // Result item
    typedef struct packed {
        t_data               read_value;
        logic [1:0]          status;
        logic [COUNT_W-1:0]  count;
    } t_result;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic  ins;
        logic  del;
        logic  rd;
        t_pos  pos;
    } t_cmd;

endpackage

>>> hdl/indexed_list_insert_delete.sv
// Top level of the indexed list: control sequencer, row of storage cells
// and read tree. Depends on ilid_pkg, ilid_cell and ilid_rdtree.
//
//  Channel   Direction  Ports                     Transfer when
//  command   in         start, busy, i_item       start high and busy low
//  result    out        o_valid, o_result         o_valid high (one cycle)
//
// An accepted item is decoded in S_EXEC, which applies the shift across all
// cells while the read tree samples, then passes through the registered read
// tree in S_OUT; the result is then shown on the ports. busy is high in both
// states; a new item can be accepted while the result is shown.
// i_rst_n is synchronous and clears the count and control; cell contents are
// not reset. Results cannot be stalled.
`timescale 1ns / 1ps

module indexed_list_insert_delete (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ilid_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_valid,
    output ilid_pkg::t_result o_result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    ilid_pkg::t_item         r_item;
    ilid_pkg::t_cnt          r_count;
    ilid_pkg::t_cnt          n_count;
    logic [1:0]              r_status;
    logic [1:0]              n_status;
    logic                    r_rd_ok;
    logic                    n_rd_ok;
    ilid_pkg::t_cmd          cmd;
    logic [ilid_pkg::CMP_W-1:0] cnt_ext;
    logic [ilid_pkg::CMP_W-1:0] pos_ext;
    logic [ilid_pkg::CMP_W-1:0] ins_pos;
    logic                    is_ins;
    logic                    accept;
    ilid_pkg::t_data         tree_value;

    logic [ilid_pkg::CAPACITY-1:0][ilid_pkg::DATA_W-1:0] cell_data;
    logic [ilid_pkg::CAPACITY-1:0][ilid_pkg::DATA_W-1:0] cell_rd;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign cnt_ext = ilid_pkg::CMP_W'(r_count);
    assign pos_ext = ilid_pkg::CMP_W'(r_item.position);

    // Decode the held item into a row command, status and next count
    always_comb begin
        cmd      = '0;
        n_count  = r_count;
        n_status = ilid_pkg::ST_BAD_POS;
        n_rd_ok  = 1'b0;
        is_ins   = 1'b0;
        ins_pos  = pos_ext;
        case (r_item.op)
            ilid_pkg::OP_READ: begin
                is_ins = 1'b0;
            end
            ilid_pkg::OP_INS_HEAD: begin
                is_ins  = 1'b1;
                ins_pos = '0;
            end
            ilid_pkg::OP_INS_TAIL: begin
                is_ins  = 1'b1;
                ins_pos = cnt_ext;
            end
            ilid_pkg::OP_INS_AT: begin
                is_ins = 1'b1;
            end
            default: begin
                is_ins = 1'b0;
            end
        endcase
        if (r_state == S_EXEC) begin
            if (r_item.op == ilid_pkg::OP_READ) begin
                cmd.rd  = 1'b1;
                cmd.pos = r_item.position;
                if (pos_ext < cnt_ext) begin
                    n_rd_ok  = 1'b1;
                    n_status = ilid_pkg::ST_DONE;
                end
            end else if (is_ins) begin
                if (ins_pos > cnt_ext) begin
                    n_status = ilid_pkg::ST_BAD_POS;
                end else if (cnt_ext >= ilid_pkg::CMP_W'(ilid_pkg::CAPACITY)) begin
                    n_status = ilid_pkg::ST_FULL;
                end else begin
                    cmd.ins  = 1'b1;
                    cmd.pos  = ins_pos[ilid_pkg::POS_W-1:0];
                    n_count  = r_count + 1'b1;
                    n_status = ilid_pkg::ST_DONE;
                end
            end else if (r_item.op == ilid_pkg::OP_DELETE) begin
                if (pos_ext < cnt_ext) begin
                    cmd.del  = 1'b1;
                    cmd.pos  = r_item.position;
                    n_count  = r_count - 1'b1;
                    n_status = ilid_pkg::ST_DONE;
                end
            end
        end else begin
            n_status = r_status;
            n_rd_ok  = r_rd_ok;
        end
    end

    // Sequencer
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            o_valid <= (r_state == S_OUT);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_status <= n_status;
        r_rd_ok  <= n_rd_ok;
        if (r_state == S_OUT) begin
            o_result.read_value <= r_rd_ok ? tree_value : '1;
            o_result.status     <= r_status;
            o_result.count      <= cnt_ext[ilid_pkg::COUNT_W-1:0];
        end
    end

    // Row of storage cells
    genvar k;
    generate
        for (k = 0; k < ilid_pkg::CAPACITY; k++) begin : g_cell
            logic [ilid_pkg::DATA_W-1:0] lo;
            logic [ilid_pkg::DATA_W-1:0] hi;
            if (k == 0) begin : g_first
                assign lo = cell_data[k];
            end else begin : g_lo
                assign lo = cell_data[k-1];
            end
            if (k == ilid_pkg::CAPACITY - 1) begin : g_last
                assign hi = cell_data[k];
            end else begin : g_hi
                assign hi = cell_data[k+1];
            end
            ilid_cell u_cell (
                .i_clk   (i_clk),
                .i_idx   (ilid_pkg::t_pos'(k)),
                .i_cmd   (cmd),
                .i_value (r_item.value),
                .i_lo    (ilid_pkg::t_data'(lo)),
                .i_hi    (ilid_pkg::t_data'(hi)),
                .o_data  (cell_data[k]),
                .o_rd    (cell_rd[k])
            );
        end
    endgenerate

    // Read gather
    ilid_rdtree u_rdtree (
        .i_clk   (i_clk),
        .i_cells (cell_rd),
        .o_value (tree_value)
    );

`ifndef SYNTH
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ilid_pkg::ST_FULL))
            |-> (r_count == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY)))
        else $error("full status with room left");
`endif

endmodule

>>> hdl/ilid_cell.sv
// One storage cell of the list row: holds a single entry and trades it with
// its neighbors on insert and delete. Depends on ilid_pkg.
`timescale 1ns / 1ps

module ilid_cell (
    input  logic            i_clk,
    input  ilid_pkg::t_pos  i_idx,
    input  ilid_pkg::t_cmd  i_cmd,
    input  ilid_pkg::t_data i_value,
    input  ilid_pkg::t_data i_lo,
    input  ilid_pkg::t_data i_hi,
    output ilid_pkg::t_data o_data,
    output ilid_pkg::t_data o_rd
);

    ilid_pkg::t_data r_data;
    ilid_pkg::t_data n_data;

    // Insert pulls from the lower neighbor, delete from the upper one
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (i_idx > i_cmd.pos) begin
                n_data = i_lo;
            end else if (i_idx == i_cmd.pos) begin
                n_data = i_value;
            end
        end else if (i_cmd.del && (i_idx >= i_cmd.pos)) begin
            n_data = i_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

    // Masked contribution to the read OR-tree
    assign o_rd = (i_cmd.rd && (i_idx == i_cmd.pos)) ? r_data : '0;

endmodule

>>> hdl/ilid_rdtree.sv
// Registered OR-tree that gathers the one selected cell onto the read bus.
// Groups of eight cells are reduced and registered. Depends on ilid_pkg.
`timescale 1ns / 1ps

module ilid_rdtree (
    input  logic                                        i_clk,
    input  logic [ilid_pkg::CAPACITY-1:0][ilid_pkg::DATA_W-1:0] i_cells,
    output ilid_pkg::t_data                             o_value
);

    logic [ilid_pkg::NGROUPS-1:0][ilid_pkg::DATA_W-1:0] r_grp;
    logic [ilid_pkg::NGROUPS-1:0][ilid_pkg::DATA_W-1:0] n_grp;
    logic [ilid_pkg::DATA_W-1:0]                        sum;

    // First level: OR within each group
    always_comb begin
        n_grp = '0;
        for (int g = 0; g < ilid_pkg::NGROUPS; g++) begin
            for (int j = 0; j < ilid_pkg::GROUP; j++) begin
                if (g * ilid_pkg::GROUP + j < ilid_pkg::CAPACITY) begin
                    n_grp[g] = n_grp[g] | i_cells[g * ilid_pkg::GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    // Second level: OR across the registered groups
    always_comb begin
        sum = '0;
        for (int g = 0; g < ilid_pkg::NGROUPS; g++) begin
            sum = sum | r_grp[g];
        end
    end

    assign o_value = ilid_pkg::t_data'(sum);

endmodule
